// ===== rtl/ipms_pkg.sv =====
`default_nettype none

package ipms_pkg;

	// Kind of an emitted part, which is also the segmenter's current mode.
	typedef enum logic [2:0] {
		KIND_PLAIN   = 3'd0,
		KIND_BINHEX  = 3'd1,
		KIND_PS      = 3'd2,
		KIND_PGP_SIG = 3'd3,
		KIND_PGP_MSG = 3'd4
	} kind_t;

	// Marker indexes into the alive mask.
	localparam int NMARK = 7;
	localparam logic [2:0] MK_BINHEX_OPEN = 3'd0;
	localparam logic [2:0] MK_PS_OPEN     = 3'd1;
	localparam logic [2:0] MK_SIG_OPEN    = 3'd2;
	localparam logic [2:0] MK_MSG_OPEN    = 3'd3;
	localparam logic [2:0] MK_SIG_CLOSE   = 3'd4;
	localparam logic [2:0] MK_MSG_CLOSE   = 3'd5;
	localparam logic [2:0] MK_EOF         = 3'd6;

	// Bit of the alive mask that stays set until a NUL locks the whitespace tail.
	localparam int TAIL_FREE_BIT = 7;

	localparam logic [5:0] MK_LEN [NMARK] = '{6'd45, 6'd11, 6'd34, 6'd27, 6'd27, 6'd25, 6'd5};
	// The PGP markers only allow whitespace after them on their line, up to a NUL.
	localparam logic [NMARK-1:0] MK_TAIL = 7'b0111100;

	localparam logic [8*45-1:0] MK_STR_BINHEX_OPEN =
		"(This file must be converted with BinHex 4.0)";
	localparam logic [8*11-1:0] MK_STR_PS_OPEN =
		{"%!PS-", 8'h41, 8'h64, 8'h6f, 8'h62, 8'h65, "-"};
	localparam logic [8*34-1:0] MK_STR_SIG_OPEN = "-----BEGIN PGP SIGNED MESSAGE-----";
	localparam logic [8*27-1:0] MK_STR_MSG_OPEN = "-----BEGIN PGP MESSAGE-----";
	localparam logic [8*27-1:0] MK_STR_SIG_CLOSE = "-----END PGP SIGNATURE-----";
	localparam logic [8*25-1:0] MK_STR_MSG_CLOSE = "-----END PGP MESSAGE-----";
	localparam logic [8*5-1:0] MK_STR_EOF = "%%EOF";

	localparam logic [7:0] CHAR_NL    = 8'd10;
	localparam logic [7:0] CHAR_TAB   = 8'd9;
	localparam logic [7:0] CHAR_CR    = 8'd13;
	localparam logic [7:0] CHAR_SPACE = 8'd32;
	localparam logic [7:0] CHAR_NUL   = 8'd0;
	localparam logic [7:0] CHAR_COLON = 8'd58;

	localparam logic [5:0] COL_MAX = 6'd63;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = 2;

	typedef struct packed {
		logic [31:0] part_begin;
		logic [31:0] part_end;
		kind_t       part_kind;
		logic        closed_by_marker;
		logic        stream_done;
	} part_t;

	// Up to two results caused by one input byte.
	typedef struct packed {
		logic [1:0] count;
		part_t      part0;
		part_t      part1;
	} entry_t;

	// Character of a marker at a given column; only meaningful below its length.
	function automatic logic [7:0] mk_char(input logic [2:0] idx, input logic [5:0] col);
		logic [7:0] ch;
		ch = CHAR_NUL;
		unique case (idx)
			MK_BINHEX_OPEN: if (col < 6'd45) ch = MK_STR_BINHEX_OPEN[(6'd44 - col) * 8 +: 8];
			MK_PS_OPEN:     if (col < 6'd11) ch = MK_STR_PS_OPEN[(6'd10 - col) * 8 +: 8];
			MK_SIG_OPEN:    if (col < 6'd34) ch = MK_STR_SIG_OPEN[(6'd33 - col) * 8 +: 8];
			MK_MSG_OPEN:    if (col < 6'd27) ch = MK_STR_MSG_OPEN[(6'd26 - col) * 8 +: 8];
			MK_SIG_CLOSE:   if (col < 6'd27) ch = MK_STR_SIG_CLOSE[(6'd26 - col) * 8 +: 8];
			MK_MSG_CLOSE:   if (col < 6'd25) ch = MK_STR_MSG_CLOSE[(6'd24 - col) * 8 +: 8];
			MK_EOF:         if (col < 6'd5) ch = MK_STR_EOF[(6'd4 - col) * 8 +: 8];
			default:        ch = CHAR_NUL;
		endcase
		return ch;
	endfunction

	function automatic logic is_lwsp(input logic [7:0] b);
		return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_CR) || (b == CHAR_NL);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/ipms_front.sv =====
`default_nettype none

module ipms_front
	import ipms_pkg::*;
#(
	parameter int OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        is_final,
	input  wire logic        q_full,
	output logic             push,
	output entry_t           push_entry
);

	kind_t                  mode_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] pstart_q;
	logic [OFFSET_BITS-1:0] lstart_q;
	logic [5:0]             col_q;
	logic [7:0]             alive_q;
	logic [7:0]             prev_q;

	logic                   acc;
	logic                   is_nl;
	logic                   do_le;
	logic [OFFSET_BITS-1:0] end_v;
	logic [7:0]             alive_t;
	logic [5:0]             col_t;
	logic [7:0]             prev_t;
	logic                   lock;
	logic [NMARK-1:0]       fullv;
	kind_t                  next_mode;
	kind_t                  mode_le;
	logic                   close;
	logic [OFFSET_BITS-1:0] ps_le;
	logic                   a_valid;
	logic                   b_valid;
	part_t                  a_part;
	part_t                  b_part;

	function automatic logic [31:0] low32(input logic [OFFSET_BITS-1:0] v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

	assign byte_stall = q_full;
	assign acc        = byte_valid && !byte_stall;
	assign is_nl      = (text_byte == CHAR_NL);
	assign do_le      = is_nl || is_final;
	assign end_v      = (pos_q == '1) ? pos_q : pos_q + 1'b1;

	// Prefix matching of the current byte against every marker still alive.
	always_comb begin
		alive_t = alive_q;
		col_t   = col_q;
		prev_t  = prev_q;
		lock    = 1'b0;
		if (!is_nl) begin
			for (int i = 0; i < NMARK; i++) begin
				if (alive_q[i]) begin
					if (col_q < MK_LEN[i]) begin
						if (mk_char(3'(i), col_q) != text_byte) alive_t[i] = 1'b0;
					end else if (MK_TAIL[i] && alive_q[TAIL_FREE_BIT]) begin
						if (text_byte == CHAR_NUL) lock = 1'b1;
						else if (!is_lwsp(text_byte)) alive_t[i] = 1'b0;
					end
				end
			end
			if (lock) alive_t[TAIL_FREE_BIT] = 1'b0;
			if (col_q != COL_MAX) col_t = col_q + 6'd1;
			prev_t = text_byte;
		end
		for (int i = 0; i < NMARK; i++) begin
			fullv[i] = alive_t[i] && (col_t >= MK_LEN[i]);
		end
	end

	// Line end decision and the results it causes.
	always_comb begin
		next_mode = KIND_PLAIN;
		close     = 1'b0;
		mode_le   = mode_q;
		ps_le     = pstart_q;
		a_valid   = 1'b0;
		a_part    = '0;
		if (do_le) begin
			unique case (mode_q)
				KIND_PLAIN: begin
					if (fullv[MK_BINHEX_OPEN])   next_mode = KIND_BINHEX;
					else if (fullv[MK_PS_OPEN])  next_mode = KIND_PS;
					else if (fullv[MK_SIG_OPEN]) next_mode = KIND_PGP_SIG;
					else if (fullv[MK_MSG_OPEN]) next_mode = KIND_PGP_MSG;
					if (next_mode != KIND_PLAIN) begin
						a_valid           = (lstart_q != pstart_q);
						a_part.part_begin = low32(pstart_q);
						a_part.part_end   = low32(lstart_q);
						a_part.part_kind  = KIND_PLAIN;
						ps_le             = lstart_q;
						mode_le           = next_mode;
					end
				end
				KIND_BINHEX:  close = (col_t != 6'd0) && (prev_t == CHAR_COLON);
				KIND_PS:      close = fullv[MK_EOF];
				KIND_PGP_SIG: close = fullv[MK_SIG_CLOSE];
				KIND_PGP_MSG: close = fullv[MK_MSG_CLOSE];
				default:      mode_le = KIND_PLAIN;
			endcase
			if (close) begin
				a_valid                 = (end_v != pstart_q);
				a_part.part_begin       = low32(pstart_q);
				a_part.part_end         = low32(end_v);
				a_part.part_kind        = mode_q;
				a_part.closed_by_marker = 1'b1;
				ps_le                   = end_v;
				mode_le                 = KIND_PLAIN;
			end
		end
		// The final byte flushes whatever is left as plain text.
		b_valid                 = is_final && (ps_le != end_v);
		b_part.part_begin       = low32(ps_le);
		b_part.part_end         = low32(end_v);
		b_part.part_kind        = KIND_PLAIN;
		b_part.closed_by_marker = 1'b0;
		b_part.stream_done      = 1'b1;
		a_part.stream_done      = is_final && !b_valid;
	end

	always_comb begin
		push_entry.count = {1'b0, a_valid} + {1'b0, b_valid};
		push_entry.part0 = a_valid ? a_part : b_part;
		push_entry.part1 = b_part;
		push             = acc && (a_valid || b_valid);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= KIND_PLAIN;
			pos_q    <= '0;
			pstart_q <= '0;
			lstart_q <= '0;
			col_q    <= '0;
			alive_q  <= '1;
			prev_q   <= '0;
		end else if (acc) begin
			if (is_final) begin
				// A new stream starts from offset zero with the next beat.
				mode_q   <= KIND_PLAIN;
				pos_q    <= '0;
				pstart_q <= '0;
				lstart_q <= '0;
				col_q    <= '0;
				alive_q  <= '1;
				prev_q   <= '0;
			end else begin
				pos_q  <= end_v;
				prev_q <= prev_t;
				if (do_le) begin
					mode_q   <= mode_le;
					pstart_q <= ps_le;
					lstart_q <= end_v;
					col_q    <= '0;
					alive_q  <= '1;
				end else begin
					col_q   <= col_t;
					alive_q <= alive_t;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipms_queue.sv =====
`default_nettype none

module ipms_queue
	import ipms_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire entry_t  push_entry,
	output logic         full,
	output logic         head_valid,
	output entry_t       head_entry,
	input  wire logic    pop
);

	entry_t               mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0]   count_q;

	assign full       = (count_q == (QPTR_BITS + 1)'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/ipms_back.sv =====
`default_nettype none

module ipms_back
	import ipms_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    head_valid,
	input  wire entry_t  head_entry,
	output logic         pop,
	output logic         part_valid,
	input  wire logic    part_stall,
	output logic [31:0]  part_begin,
	output logic [31:0]  part_end,
	output logic [2:0]   part_kind,
	output logic         closed_by_marker,
	output logic         stream_done
);

	logic  valid_q;
	logic  sub_q;
	part_t out_q;
	part_t sel;
	logic  can_load;
	logic  last;

	// The output register may be refilled when empty or when its beat is taken.
	assign can_load = !valid_q || !part_stall;
	assign sel      = sub_q ? head_entry.part1 : head_entry.part0;
	assign last     = sub_q || (head_entry.count == 2'd1);
	assign pop      = can_load && head_valid && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			sub_q   <= 1'b0;
		end else if (can_load) begin
			valid_q <= head_valid;
			if (head_valid) sub_q <= !last;
		end
	end

	always_ff @(posedge clk) begin
		if (can_load && head_valid) out_q <= sel;
	end

	assign part_valid       = valid_q;
	assign part_begin       = out_q.part_begin;
	assign part_end         = out_q.part_end;
	assign part_kind        = out_q.part_kind;
	assign closed_by_marker = out_q.closed_by_marker;
	assign stream_done      = out_q.stream_done;

endmodule

`default_nettype wire

// ===== rtl/inline_part_marker_segmenter.sv =====
// Inline part marker segmenter.
// The byte channel (byte_valid, byte_stall, text_byte, is_final) takes one byte of a
// text stream per beat; is_final marks the last byte and flushes the stream.
// The part channel (part_valid, part_stall, part_begin, part_end, part_kind,
// closed_by_marker, stream_done) gives each non-empty part found by the whole-line
// markers, at most two parts per input byte, in stream order.
// Throughput: one byte per cycle while the queue is not full. The front end keeps
// the per-line matching state and classifies every byte combinationally;
// the back end sends one part per cycle unless part_stall holds it. A part is queued
// with its byte's beat, then goes to the output register; a second part follows it.
// A four-entry queue sits between front and back. When the receiver stalls, parts
// pile up there and byte_stall rises only once the queue is full; bytes that cause
// no part do not use the queue.
// After the final byte all offsets and matching state return to their reset values.
// Reset (arst_n low) empties the queue and the output register and starts a new
// stream at offset zero. Offsets are counted in OFFSET_BITS bits and saturate.
`default_nettype none

module inline_part_marker_segmenter
	import ipms_pkg::*;
#(
	parameter int OFFSET_BITS = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        byte_valid,
	output logic             byte_stall,
	input  wire logic [7:0]  text_byte,
	input  wire logic        is_final,
	output logic             part_valid,
	input  wire logic        part_stall,
	output logic [31:0]      part_begin,
	output logic [31:0]      part_end,
	output logic [2:0]       part_kind,
	output logic             closed_by_marker,
	output logic             stream_done
);

	logic   q_full;
	logic   push;
	entry_t push_entry;
	logic   head_valid;
	entry_t head_entry;
	logic   pop;

	ipms_front #(
		.OFFSET_BITS(OFFSET_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.text_byte  (text_byte),
		.is_final   (is_final),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	ipms_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop)
	);

	ipms_back u_back (
		.clk              (clk),
		.arst_n           (arst_n),
		.head_valid       (head_valid),
		.head_entry       (head_entry),
		.pop              (pop),
		.part_valid       (part_valid),
		.part_stall       (part_stall),
		.part_begin       (part_begin),
		.part_end         (part_end),
		.part_kind        (part_kind),
		.closed_by_marker (closed_by_marker),
		.stream_done      (stream_done)
	);

endmodule

`default_nettype wire

// ===== rtl/ipms_checker.sv =====
`default_nettype none

module ipms_checker
	import ipms_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        byte_valid,
	input wire logic        byte_stall,
	input wire logic [7:0]  text_byte,
	input wire logic        is_final,
	input wire logic        part_valid,
	input wire logic        part_stall,
	input wire logic [31:0] part_begin,
	input wire logic [31:0] part_end,
	input wire logic [2:0]  part_kind,
	input wire logic        closed_by_marker,
	input wire logic        stream_done
);

	// Where the next part of the stream must begin: parts tile the stream.
	logic [31:0] expect_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expect_q <= '0;
		end else if (part_valid && !part_stall) begin
			expect_q <= stream_done ? 32'd0 : part_end;
		end
	end

	a_parts_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		part_valid |-> part_begin == expect_q)
		else $error("part does not start where the previous part ended");

	a_closed_means_embedded: assert property (@(posedge clk) disable iff (!arst_n)
		part_valid |-> closed_by_marker == (part_kind != KIND_PLAIN))
		else $error("closing marker flag disagrees with part kind");

	a_part_held: assert property (@(posedge clk) disable iff (!arst_n)
		part_valid && part_stall |=> part_valid && $stable(part_begin)
			&& $stable(part_end) && $stable(part_kind)
			&& $stable(closed_by_marker) && $stable(stream_done))
		else $error("stalled part beat changed");

	a_byte_held: assert property (@(posedge clk) disable iff (!arst_n)
		byte_valid && byte_stall |=> byte_valid && $stable(text_byte) && $stable(is_final))
		else $error("stalled byte beat changed");

endmodule

bind inline_part_marker_segmenter ipms_checker u_ipms_checker (.*);

`default_nettype wire

// ===== dv/tb_inline_part_marker_segmenter.sv =====
module tb_inline_part_marker_segmenter;
	import ipms_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [8*45-1:0] BINHEX_OPENER =
		"(This file must be converted with BinHex 4.0)";
	localparam logic [8*11-1:0] PS_OPENER =
		{"%!PS-", 8'h41, 8'h64, 8'h6f, 8'h62, 8'h65, "-"};
	localparam logic [8*34-1:0] SIG_OPENER = "-----BEGIN PGP SIGNED MESSAGE-----";
	localparam logic [8*27-1:0] MSG_OPENER = "-----BEGIN PGP MESSAGE-----";
	localparam logic [8*27-1:0] SIG_CLOSER = "-----END PGP SIGNATURE-----";
	localparam logic [8*25-1:0] MSG_CLOSER = "-----END PGP MESSAGE-----";
	localparam logic [8*5-1:0] EOF_CLOSER = "%%EOF";

	localparam int TAIL_OPEN_BIT = 7;
	localparam logic [31:0] OFFSET_TOP = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [31:0] begin_at;
		logic [31:0] end_at;
		kind_t       kind;
		logic        closed;
		logic        done;
	} part_rec_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_stall;
	logic [7:0]  text_byte = 8'd0;
	logic        is_final = 1'b0;
	logic        part_valid;
	logic        part_stall = 1'b0;
	logic [31:0] part_begin;
	logic [31:0] part_end;
	logic [2:0]  part_kind;
	logic        closed_by_marker;
	logic        stream_done;

	inline_part_marker_segmenter dut (.*);

	// Segmenter state as the byte stream has been seen so far.
	kind_t       seg_mode;
	logic [31:0] byte_pos;
	logic [31:0] part_from;
	logic [31:0] line_from;
	logic [5:0]  line_col;
	logic [7:0]  alive_mask;
	logic [7:0]  last_byte;

	part_rec_t   step_parts [2];
	int          step_count;
	part_rec_t   pending_parts [$];
	logic [7:0]  stream_q [$];

	int          send_idle;
	int          recv_idle;
	int unsigned bytes_sent;
	int unsigned streams_sent;
	int unsigned parts_checked;
	int unsigned closed_seen;
	int unsigned flushes_seen;
	int unsigned mismatches;

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	function automatic int mark_len(input logic [2:0] idx);
		case (idx)
			MK_BINHEX_OPEN: return 45;
			MK_PS_OPEN:     return 11;
			MK_SIG_OPEN:    return 34;
			MK_MSG_OPEN:    return 27;
			MK_SIG_CLOSE:   return 27;
			MK_MSG_CLOSE:   return 25;
			MK_EOF:         return 5;
			default:        return 0;
		endcase
	endfunction

	function automatic logic mark_has_tail(input logic [2:0] idx);
		return idx == MK_SIG_OPEN || idx == MK_MSG_OPEN || idx == MK_SIG_CLOSE ||
			idx == MK_MSG_CLOSE;
	endfunction

	function automatic logic [7:0] marker_char(input logic [2:0] idx, input int col);
		case (idx)
			MK_BINHEX_OPEN: return BINHEX_OPENER[(44 - col) * 8 +: 8];
			MK_PS_OPEN:     return PS_OPENER[(10 - col) * 8 +: 8];
			MK_SIG_OPEN:    return SIG_OPENER[(33 - col) * 8 +: 8];
			MK_MSG_OPEN:    return MSG_OPENER[(26 - col) * 8 +: 8];
			MK_SIG_CLOSE:   return SIG_CLOSER[(26 - col) * 8 +: 8];
			MK_MSG_CLOSE:   return MSG_CLOSER[(24 - col) * 8 +: 8];
			MK_EOF:         return EOF_CLOSER[(4 - col) * 8 +: 8];
			default:        return CHAR_NUL;
		endcase
	endfunction

	function automatic logic is_blank(input logic [7:0] b);
		return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_CR || b == CHAR_NL;
	endfunction

	function automatic kind_t opener_kind(input logic [2:0] idx);
		case (idx)
			MK_BINHEX_OPEN: return KIND_BINHEX;
			MK_PS_OPEN:     return KIND_PS;
			MK_SIG_OPEN:    return KIND_PGP_SIG;
			default:        return KIND_PGP_MSG;
		endcase
	endfunction

	function automatic void clear_tracker();
		seg_mode = KIND_PLAIN;
		byte_pos = '0;
		part_from = '0;
		line_from = '0;
		line_col = '0;
		alive_mask = '1;
		last_byte = '0;
	endfunction

	function automatic logic marker_full(input logic [2:0] idx);
		return alive_mask[idx] && line_col >= mark_len(idx);
	endfunction

	function automatic void note_part(input logic [31:0] b, input logic [31:0] e,
			input kind_t k, input logic closed);
		if (e != b && step_count < 2) begin
			step_parts[step_count].begin_at = b;
			step_parts[step_count].end_at = e;
			step_parts[step_count].kind = k;
			step_parts[step_count].closed = closed;
			step_parts[step_count].done = 1'b0;
			step_count++;
		end
	endfunction

	function automatic void absorb_byte(input logic [7:0] b);
		logic lock;
		int i;
		lock = 1'b0;
		for (i = 0; i < NMARK; i++) begin
			if (alive_mask[i]) begin
				if (line_col < mark_len(3'(i))) begin
					if (marker_char(3'(i), int'(line_col)) != b)
						alive_mask[i] = 1'b0;
				end else if (mark_has_tail(3'(i)) && alive_mask[TAIL_OPEN_BIT]) begin
					// A NUL after a PGP marker makes the rest of the line irrelevant.
					if (b == CHAR_NUL)
						lock = 1'b1;
					else if (!is_blank(b))
						alive_mask[i] = 1'b0;
				end
			end
		end
		if (lock)
			alive_mask[TAIL_OPEN_BIT] = 1'b0;
		if (line_col != 6'd63)
			line_col++;
		last_byte = b;
	endfunction

	function automatic void close_line(input logic [31:0] e);
		kind_t nxt;
		logic  ends_part;
		nxt = KIND_PLAIN;
		ends_part = 1'b0;
		case (seg_mode)
			KIND_PLAIN: begin
				if (marker_full(MK_BINHEX_OPEN))
					nxt = KIND_BINHEX;
				else if (marker_full(MK_PS_OPEN))
					nxt = KIND_PS;
				else if (marker_full(MK_SIG_OPEN))
					nxt = KIND_PGP_SIG;
				else if (marker_full(MK_MSG_OPEN))
					nxt = KIND_PGP_MSG;
				if (nxt != KIND_PLAIN) begin
					note_part(part_from, line_from, KIND_PLAIN, 1'b0);
					part_from = line_from;
					seg_mode = nxt;
				end
			end
			KIND_BINHEX:  ends_part = line_col != 0 && last_byte == CHAR_COLON;
			KIND_PS:      ends_part = marker_full(MK_EOF);
			KIND_PGP_SIG: ends_part = marker_full(MK_SIG_CLOSE);
			KIND_PGP_MSG: ends_part = marker_full(MK_MSG_CLOSE);
			default:      seg_mode = KIND_PLAIN;
		endcase
		if (ends_part) begin
			note_part(part_from, e, seg_mode, 1'b1);
			part_from = e;
			seg_mode = KIND_PLAIN;
		end
		line_from = e;
		line_col = '0;
		alive_mask = '1;
	endfunction

	function automatic void segment_byte(input logic [7:0] b, input logic fin);
		logic [31:0] e;
		int i;
		e = (byte_pos == OFFSET_TOP) ? byte_pos : byte_pos + 1;
		step_count = 0;
		if (b == CHAR_NL) begin
			close_line(e);
		end else begin
			absorb_byte(b);
			// An unterminated last line is judged as if its newline followed.
			if (fin)
				close_line(e);
		end
		byte_pos = e;
		if (fin) begin
			note_part(part_from, e, KIND_PLAIN, 1'b0);
			if (step_count > 0)
				step_parts[step_count - 1].done = 1'b1;
			clear_tracker();
		end
		for (i = 0; i < step_count; i++)
			pending_parts.push_back(step_parts[i]);
	endfunction

	function automatic void check_part();
		part_rec_t want;
		if (pending_parts.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("Unexpected part: begin %0d end %0d kind %0d closed %b done %b",
					part_begin, part_end, part_kind, closed_by_marker, stream_done);
		end else begin
			want = pending_parts.pop_front();
			parts_checked++;
			if (closed_by_marker)
				closed_seen++;
			if (stream_done)
				flushes_seen++;
			if (part_begin !== want.begin_at || part_end !== want.end_at ||
					part_kind !== want.kind || closed_by_marker !== want.closed ||
					stream_done !== want.done) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Part mismatch: expected begin %0d end %0d kind %0d closed %b done %b",
						want.begin_at, want.end_at, want.kind, want.closed, want.done);
					$display("               got      begin %0d end %0d kind %0d closed %b done %b",
						part_begin, part_end, part_kind, closed_by_marker, stream_done);
				end
			end
		end
	endfunction

	// Results are checked before the byte of the same edge is predicted, so a part
	// can never be matched against an expectation raised by its own edge.
	always @(posedge clk) begin
		if (arst_n && part_valid && !part_stall)
			check_part();
		if (arst_n && byte_valid && !byte_stall)
			segment_byte(text_byte, is_final);
	end

	always @(posedge clk) begin
		part_stall <= ($urandom_range(99) < recv_idle);
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(99) < send_idle) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		text_byte <= b;
		is_final <= fin;
		@(posedge clk);
		while (byte_stall)
			@(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_stream();
		int i;
		int n;
		n = stream_q.size();
		for (i = 0; i < n; i++)
			send_byte(stream_q[i], i == n - 1);
		stream_q.delete();
		streams_sent++;
	endtask

	function automatic void put_byte(input logic [7:0] b);
		stream_q.push_back(b);
	endfunction

	function automatic void put_marker(input logic [2:0] idx);
		int c;
		for (c = 0; c < mark_len(idx); c++)
			stream_q.push_back(marker_char(idx, c));
	endfunction

	// Newlines are turned into colons, which keeps BinHex closers turning up by chance.
	function automatic void put_random_text(input int n);
		logic [7:0] b;
		int i;
		for (i = 0; i < n; i++) begin
			b = 8'($urandom_range(255));
			if (b == CHAR_NL)
				b = CHAR_COLON;
			stream_q.push_back(b);
		end
	endfunction

	function automatic logic [7:0] blank_byte();
		case ($urandom_range(2))
			0:       return CHAR_SPACE;
			1:       return CHAR_TAB;
			default: return CHAR_CR;
		endcase
	endfunction

	function automatic void put_pgp_tail();
		int i;
		int n;
		n = $urandom_range(0, 3);
		case ($urandom_range(4))
			0: ;
			1: for (i = 0; i < n; i++) put_byte(blank_byte());
			2: begin
				for (i = 0; i < n; i++) put_byte(blank_byte());
				put_byte(CHAR_NUL);
				put_random_text($urandom_range(0, 6));
			end
			3: put_random_text($urandom_range(1, 4));
			default: begin
				put_byte(blank_byte());
				put_random_text($urandom_range(1, 4));
			end
		endcase
	endfunction

	function automatic void put_broken_marker(input logic [2:0] idx);
		logic [7:0] ch;
		int len;
		int cut;
		int c;
		len = mark_len(idx);
		cut = $urandom_range(len - 1);
		if ($urandom_range(1)) begin
			for (c = 0; c < cut; c++)
				put_byte(marker_char(idx, c));
			put_random_text($urandom_range(0, 4));
		end else begin
			for (c = 0; c < len; c++) begin
				ch = marker_char(idx, c);
				if (c == cut) begin
					ch = ch ^ (8'd1 << $urandom_range(7));
					if (ch == CHAR_NL)
						ch = 8'h7F;
				end
				put_byte(ch);
			end
		end
	endfunction

	function automatic void put_closer(input kind_t k);
		case (k)
			KIND_BINHEX: begin
				put_random_text($urandom_range(0, 12));
				put_byte(CHAR_COLON);
				if ($urandom_range(9) == 0)
					put_byte(CHAR_CR);
			end
			KIND_PS: begin
				put_marker(MK_EOF);
				put_random_text($urandom_range(0, 6));
			end
			KIND_PGP_SIG: begin
				put_marker(MK_SIG_CLOSE);
				put_pgp_tail();
			end
			default: begin
				put_marker(MK_MSG_CLOSE);
				put_pgp_tail();
			end
		endcase
	endfunction

	// Mostly well-formed opener/body/closer lines with random content, with broken
	// markers, plain text and very short streams mixed in.
	function automatic void build_stream();
		kind_t      gmode;
		logic [2:0] idx;
		int         lines;
		int         k;
		int         pick;
		gmode = KIND_PLAIN;
		if ($urandom_range(3) == 0) begin
			lines = $urandom_range(1, 4);
			for (k = 0; k < lines; k++)
				if ($urandom_range(3) == 0)
					put_byte(CHAR_NL);
				else
					put_random_text(1);
		end else begin
			lines = $urandom_range(1, 6);
			for (k = 0; k < lines; k++) begin
				pick = $urandom_range(99);
				if (gmode == KIND_PLAIN) begin
					if (pick < 45) begin
						idx = 3'($urandom_range(MK_MSG_OPEN, MK_BINHEX_OPEN));
						put_marker(idx);
						if (mark_has_tail(idx))
							put_pgp_tail();
						else
							put_random_text($urandom_range(0, 6));
						gmode = opener_kind(idx);
					end else if (pick < 60) begin
						put_broken_marker(3'($urandom_range(NMARK - 1)));
					end else begin
						put_random_text(($urandom_range(9) == 0) ? 70 : $urandom_range(0, 16));
					end
				end else begin
					if (pick < 55) begin
						put_closer(gmode);
						gmode = KIND_PLAIN;
					end else if (pick < 70) begin
						put_broken_marker(3'($urandom_range(NMARK - 1)));
					end else begin
						put_random_text(($urandom_range(9) == 0) ? 70 : $urandom_range(0, 24));
					end
				end
				if (k < lines - 1 || $urandom_range(1))
					put_byte(CHAR_NL);
			end
		end
		if (stream_q.size() == 0)
			put_random_text(1);
	endfunction

	task automatic test_byte_extremes();
		put_byte(8'h00);
		put_byte(8'hFF);
		put_byte(CHAR_NL);
		put_byte(8'hFF);
		send_stream();
		put_byte(CHAR_NL);
		send_stream();
		put_byte(8'h00);
		send_stream();
		// A line long enough to saturate the column count.
		put_random_text(70);
		put_byte(CHAR_NL);
		put_byte(8'hFF);
		send_stream();
	endtask

	task automatic test_openers();
		logic [2:0] idx;
		for (idx = MK_BINHEX_OPEN; idx <= MK_MSG_OPEN; idx++) begin
			// Opener on the very first line: the empty plain part is not emitted.
			put_marker(idx);
			put_byte(CHAR_NL);
			put_random_text(5);
			put_byte(CHAR_NL);
			put_closer(opener_kind(idx));
			put_byte(CHAR_NL);
			put_random_text(3);
			send_stream();
			// Opener after some text and no closer: the flush ends the part as plain.
			put_random_text(4);
			put_byte(CHAR_NL);
			put_marker(idx);
			put_byte(CHAR_NL);
			put_random_text(6);
			send_stream();
		end
	endtask

	task automatic test_closers();
		put_marker(MK_SIG_OPEN);
		put_byte(CHAR_NL);
		put_marker(MK_SIG_CLOSE);
		put_byte(CHAR_TAB);
		put_byte(CHAR_SPACE);
		put_byte(CHAR_CR);
		put_byte(CHAR_NL);
		put_marker(MK_MSG_OPEN);
		put_byte(CHAR_NUL);
		put_byte("x");
		put_byte(CHAR_NL);
		put_marker(MK_MSG_CLOSE);
		put_byte("x");
		put_byte(CHAR_NL);
		put_marker(MK_MSG_CLOSE);
		put_byte(CHAR_SPACE);
		put_byte(CHAR_NUL);
		put_byte("x");
		put_byte(CHAR_NL);
		put_byte(CHAR_NL);
		send_stream();
		// A colon ending the opener line must not let the empty line after it close.
		put_marker(MK_BINHEX_OPEN);
		put_byte(CHAR_COLON);
		put_byte(CHAR_NL);
		put_byte(CHAR_NL);
		put_byte("a");
		put_byte(CHAR_COLON);
		put_byte(CHAR_CR);
		put_byte(CHAR_NL);
		put_byte(CHAR_COLON);
		put_byte(CHAR_NL);
		put_marker(MK_PS_OPEN);
		put_byte(CHAR_NL);
		put_marker(MK_EOF);
		put_byte("j");
		put_byte(CHAR_NL);
		put_byte("z");
		send_stream();
	endtask

	task automatic test_unterminated_lines();
		put_marker(MK_PS_OPEN);
		put_byte(CHAR_NL);
		put_marker(MK_EOF);
		send_stream();
		put_random_text(3);
		put_byte(CHAR_NL);
		put_marker(MK_SIG_OPEN);
		send_stream();
		put_marker(MK_BINHEX_OPEN);
		put_byte(CHAR_NL);
		put_random_text(4);
		put_byte(CHAR_COLON);
		send_stream();
	endtask

	task automatic test_random_streams(input int unsigned byte_target);
		while (bytes_sent < byte_target) begin
			build_stream();
			send_stream();
		end
	endtask

	initial begin
		send_idle = 9;
		recv_idle = 70;
		bytes_sent = 0;
		streams_sent = 0;
		parts_checked = 0;
		closed_seen = 0;
		flushes_seen = 0;
		mismatches = 0;
		clear_tracker();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_byte_extremes();
		test_openers();
		test_closers();
		test_unterminated_lines();
		test_random_streams(650);
		send_idle = 70;
		recv_idle = 9;
		test_random_streams(1150);
		send_idle = 0;
		recv_idle = 0;
		test_random_streams(1650);

		byte_valid <= 1'b0;
		while (pending_parts.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d bytes in %0d streams and checked %0d parts.",
			bytes_sent, streams_sent, parts_checked);
		$display("%0d parts ended at a closing marker, %0d ended a stream, %0d mismatches.",
			closed_seen, flushes_seen, mismatches);
		if (mismatches == 0 && pending_parts.size() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
